@@ hdl/tga_pkg.sv @@
// ============================================================================
// tga_pkg
// shared types and constants of the tga run-length pixel decoder
// ============================================================================
`default_nettype none

package tga_pkg;

    // result kind codes as seen on the output channel
    typedef enum logic [1:0] {
        KIND_PIXEL    = 2'd0,
        KIND_HDR_OK   = 2'd1,
        KIND_BAD_TYPE = 2'd2,
        KIND_BAD_FMT  = 2'd3
    } t_kind;

    // alpha of pixels from 24-bit images
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    // one classified command from the parser to the segment generator
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  count;   // pixels in a run, 1..128, pixel kind only
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] width;   // header accepted only
        logic [15:0] height;  // header accepted only
        logic        flip;    // header accepted only
    } t_cmd;

    // command queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

@@ hdl/tga_if.sv @@
// ============================================================================
// tga_in_if / tga_out_if
// valid/ready channels for file bytes in and decoded results out
// ============================================================================
`default_nettype none

interface tga_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_file;

    modport source (output valid, data_byte, start_of_file, input ready);
    modport sink   (input valid, data_byte, start_of_file, output ready);
endinterface

interface tga_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] dest_row;
    logic [15:0] dest_col;
    logic [7:0]  seg_len;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] img_width;
    logic [15:0] img_height;
    logic        image_done;
    logic        last;

    modport source (output valid, kind, dest_row, dest_col, seg_len, red, green, blue,
                    alpha, img_width, img_height, image_done, last, input ready);
    modport sink   (input valid, kind, dest_row, dest_col, seg_len, red, green, blue,
                    alpha, img_width, img_height, image_done, last, output ready);
endinterface

`default_nettype wire

@@ hdl/tga_rle_pixel_decoder.sv @@
// ============================================================================
// tga_rle_pixel_decoder
// streaming decoder for uncompressed and run-length tga images
// ============================================================================
// The block takes a tga file one byte per request on i_in_ch; start_of_file
// marks header byte 0 and restarts parsing from any point. On the last of the
// 18 header bytes it returns one verdict (header accepted with the
// dimensions, bad image type, or bad format), then skips the id field and
// returns pixels as rgba segments, one per destination row, with the vertical
// flip applied. A parser accepts one byte per cycle while the command queue
// has room; bytes that complete a pixel push one command. The segment
// generator loads a command and then gives its results in turn, taking the
// next command only after the last result of the current one, so a pixel of
// 3 or 4 bytes keeps up with the byte stream, while a run gives one result
// for each row that it touches; long runs over narrow rows fill the queue and
// hold off the input. Results wait in an output register, so a stalled sink
// does not stop parsing until the queue is full.
// ============================================================================
`default_nettype none

module tga_rle_pixel_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tga_in_if.sink    i_in_ch,
    tga_out_if.source o_out_ch
);

    // parser to queue
    logic             w_push;
    tga_pkg::t_cmd    w_cmd_in;

    // queue to segment generator
    logic             w_pop;
    tga_pkg::t_cmd    w_cmd_out;
    tga_pkg::t_q_stat w_q_stat;

    // front: header checks, id skip, packet headers and pixel assembly;
    // it also counts pixels left so bytes after the image end are ignored
    tga_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (i_in_ch),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_cmd    (w_cmd_in)
    );

    // decouples byte intake from segment output
    tga_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_stat  (w_q_stat)
    );

    // back: tracks column and source row, cuts runs at row ends
    tga_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd_out),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out_ch (o_out_ch)
    );

endmodule

`default_nettype wire

@@ hdl/tga_front.sv @@
// ============================================================================
// tga_front
// byte parser: header, id skip, packet and pixel assembly into run commands
// ============================================================================
`default_nettype none

module tga_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tga_in_if.sink           i_in_ch,
    input  tga_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output tga_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_HEADER = 4'b0010,
        ST_IDSKIP = 4'b0100,
        ST_PIXEL  = 4'b1000
    } t_state;

    // header byte offsets
    localparam logic [4:0] HDR_ID_LEN    = 5'd0;
    localparam logic [4:0] HDR_CMAP_TYPE = 5'd1;
    localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH     = 5'd16;
    localparam logic [4:0] HDR_DESC      = 5'd17;

    localparam logic [7:0]  TYPE_RAW  = 8'd2;
    localparam logic [7:0]  TYPE_RLE  = 8'd10;
    localparam logic [7:0]  DEPTH_24  = 8'd24;
    localparam logic [7:0]  DEPTH_32  = 8'd32;
    localparam logic [15:0] MIN_WIDTH = 16'd3;

    t_state      r_state,        n_state;
    logic [4:0]  r_hidx,         n_hidx;
    logic [7:0]  r_id_skip,      n_id_skip;
    logic        r_type_ok,      n_type_ok;
    logic        r_is_rle,       n_is_rle;
    logic        r_cmap,         n_cmap;
    logic        r_bpp_ok,       n_bpp_ok;
    logic        r_bpp4,         n_bpp4;
    logic [15:0] r_width,        n_width;
    logic [15:0] r_height,       n_height;
    logic [31:0] r_total,        n_total;
    logic [31:0] r_remaining,    n_remaining;
    logic [7:0]  r_packet_left,  n_packet_left;
    logic        r_packet_run,   n_packet_run;
    logic [1:0]  r_pix_idx,      n_pix_idx;
    logic [23:0] r_pix,          n_pix;

    logic        w_accept;
    t_state      w_state;
    logic [4:0]  w_hidx;
    logic [7:0]  w_byte;
    logic [23:0] w_pix;
    logic        w_pix_done;
    logic [7:0]  w_alpha;
    logic [7:0]  w_count;
    logic [7:0]  w_clip;
    logic [31:0] w_prod;

    assign i_in_ch.ready = !i_q_stat.full;
    assign w_prod        = r_width * r_height;

    always_comb begin
        n_state       = r_state;
        n_hidx        = r_hidx;
        n_id_skip     = r_id_skip;
        n_type_ok     = r_type_ok;
        n_is_rle      = r_is_rle;
        n_cmap        = r_cmap;
        n_bpp_ok      = r_bpp_ok;
        n_bpp4        = r_bpp4;
        n_width       = r_width;
        n_height      = r_height;
        n_total       = r_total;
        n_remaining   = r_remaining;
        n_packet_left = r_packet_left;
        n_packet_run  = r_packet_run;
        n_pix_idx     = r_pix_idx;
        n_pix         = r_pix;
        o_push        = 1'b0;
        o_cmd         = '0;

        w_accept = i_in_ch.valid && i_in_ch.ready;
        w_byte   = i_in_ch.data_byte;
        w_state  = i_in_ch.start_of_file ? ST_HEADER : r_state;
        w_hidx   = i_in_ch.start_of_file ? HDR_ID_LEN : r_hidx;

        // little-endian bgr gathering
        w_pix = r_pix;
        case (r_pix_idx)
            2'd0:    w_pix[7:0]   = w_byte;
            2'd1:    w_pix[15:8]  = w_byte;
            2'd2:    w_pix[23:16] = w_byte;
            default: ;
        endcase
        w_pix_done = r_bpp4 ? (r_pix_idx == 2'd3) : (r_pix_idx == 2'd2);
        w_alpha    = r_bpp4 ? w_byte : tga_pkg::ALPHA_OPAQUE;
        w_count    = (r_is_rle && r_packet_run) ? r_packet_left : 8'd1;
        // pixels past the end of the image are dropped
        w_clip     = ({24'd0, w_count} > r_remaining) ? r_remaining[7:0] : w_count;

        if (w_accept) begin
            unique case (w_state)
                ST_IDLE: ;
                ST_HEADER: begin
                    n_state = ST_HEADER;
                    unique case (w_hidx)
                        HDR_ID_LEN:    n_id_skip = w_byte;
                        HDR_CMAP_TYPE: n_cmap = (w_byte != 8'd0);
                        HDR_IMG_TYPE: begin
                            n_type_ok = (w_byte == TYPE_RAW) || (w_byte == TYPE_RLE);
                            n_is_rle  = (w_byte == TYPE_RLE);
                        end
                        HDR_WIDTH_LO:  n_width[7:0]   = w_byte;
                        HDR_WIDTH_HI:  n_width[15:8]  = w_byte;
                        HDR_HEIGHT_LO: n_height[7:0]  = w_byte;
                        HDR_HEIGHT_HI: n_height[15:8] = w_byte;
                        HDR_DEPTH: begin
                            n_bpp_ok = (w_byte == DEPTH_24) || (w_byte == DEPTH_32);
                            n_bpp4   = (w_byte == DEPTH_32);
                            n_total  = w_prod;
                        end
                        default: ;
                    endcase
                    if (w_hidx != HDR_DESC) begin
                        n_hidx = w_hidx + 5'd1;
                    end else begin
                        // verdict on the descriptor byte
                        o_push = 1'b1;
                        if (!r_type_ok) begin
                            o_cmd.kind = tga_pkg::KIND_BAD_TYPE;
                            n_state    = ST_IDLE;
                        end else if (r_cmap || !r_bpp_ok || (r_width < MIN_WIDTH)) begin
                            o_cmd.kind = tga_pkg::KIND_BAD_FMT;
                            n_state    = ST_IDLE;
                        end else begin
                            o_cmd.kind    = tga_pkg::KIND_HDR_OK;
                            o_cmd.width   = r_width;
                            o_cmd.height  = r_height;
                            o_cmd.flip    = w_byte[5];
                            n_remaining   = r_total;
                            n_packet_left = 8'd0;
                            n_pix_idx     = 2'd0;
                            if (r_height == 16'd0) begin
                                n_state = ST_IDLE;
                            end else if (r_id_skip != 8'd0) begin
                                n_state = ST_IDSKIP;
                            end else begin
                                n_state = ST_PIXEL;
                            end
                        end
                    end
                end
                ST_IDSKIP: begin
                    n_id_skip = r_id_skip - 8'd1;
                    if (r_id_skip == 8'd1) begin
                        n_state = ST_PIXEL;
                    end
                end
                ST_PIXEL: begin
                    if (r_is_rle && (r_packet_left == 8'd0)) begin
                        // packet header: low seven bits are count minus one
                        n_packet_left = {1'b0, w_byte[6:0]} + 8'd1;
                        n_packet_run  = w_byte[7];
                        n_pix_idx     = 2'd0;
                    end else if (w_pix_done) begin
                        n_pix_idx = 2'd0;
                        n_pix     = w_pix;
                        if (r_is_rle) begin
                            n_packet_left = r_packet_run ? 8'd0 : (r_packet_left - 8'd1);
                        end
                        n_remaining = r_remaining - {24'd0, w_clip};
                        if (r_remaining == {24'd0, w_clip}) begin
                            n_state = ST_IDLE;
                        end
                        o_push      = 1'b1;
                        o_cmd.kind  = tga_pkg::KIND_PIXEL;
                        o_cmd.count = w_clip;
                        o_cmd.red   = w_pix[23:16];
                        o_cmd.green = w_pix[15:8];
                        o_cmd.blue  = w_pix[7:0];
                        o_cmd.alpha = w_alpha;
                    end else begin
                        n_pix     = w_pix;
                        n_pix_idx = r_pix_idx + 2'd1;
                    end
                end
                default: n_state = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_hidx        <= '0;
            r_id_skip     <= '0;
            r_type_ok     <= 1'b0;
            r_is_rle      <= 1'b0;
            r_cmap        <= 1'b0;
            r_bpp_ok      <= 1'b0;
            r_bpp4        <= 1'b0;
            r_width       <= '0;
            r_height      <= '0;
            r_total       <= '0;
            r_remaining   <= '0;
            r_packet_left <= '0;
            r_packet_run  <= 1'b0;
            r_pix_idx     <= '0;
            r_pix         <= '0;
        end else begin
            r_state       <= n_state;
            r_hidx        <= n_hidx;
            r_id_skip     <= n_id_skip;
            r_type_ok     <= n_type_ok;
            r_is_rle      <= n_is_rle;
            r_cmap        <= n_cmap;
            r_bpp_ok      <= n_bpp_ok;
            r_bpp4        <= n_bpp4;
            r_width       <= n_width;
            r_height      <= n_height;
            r_total       <= n_total;
            r_remaining   <= n_remaining;
            r_packet_left <= n_packet_left;
            r_packet_run  <= n_packet_run;
            r_pix_idx     <= n_pix_idx;
            r_pix         <= n_pix;
        end
    end

    // the decoder leaves pixel decoding as soon as the last pixel is counted
    a_pixel_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PIXEL) |-> (r_remaining != 32'd0))
        else $error("pixel state with no pixels left");

endmodule

`default_nettype wire

@@ hdl/tga_cmd_fifo.sv @@
// ============================================================================
// tga_cmd_fifo
// short command queue between the byte parser and the segment generator
// ============================================================================
`default_nettype none

module tga_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tga_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output tga_pkg::t_cmd     o_cmd,
    output tga_pkg::t_q_stat  o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tga_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : (r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : (r_rd_ptr + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_stat.full || i_pop))
        else $error("command queue overflow");

endmodule

`default_nettype wire

@@ hdl/tga_back.sv @@
// ============================================================================
// tga_back
// segment generator: splits runs at row ends and applies the vertical flip
// ============================================================================
`default_nettype none

module tga_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tga_pkg::t_cmd    i_cmd,
    input  tga_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    tga_out_if.source        o_out_ch
);

    typedef struct packed {
        tga_pkg::t_kind kind;
        logic [15:0]    dest_row;
        logic [15:0]    dest_col;
        logic [7:0]     seg_len;
        logic [7:0]     red;
        logic [7:0]     green;
        logic [7:0]     blue;
        logic [7:0]     alpha;
        logic [15:0]    img_width;
        logic [15:0]    img_height;
        logic           image_done;
        logic           last;
    } t_res;

    logic          r_busy;
    tga_pkg::t_cmd r_cur;
    logic [7:0]    r_left;
    logic [15:0]   r_col;
    logic [15:0]   r_row;     // source row, counts down to zero
    logic [15:0]   r_w;
    logic [15:0]   r_h;
    logic          r_flip;
    logic          r_out_valid;
    t_res          r_res, n_res;

    logic          w_free;
    logic          w_load;
    logic          w_fire;
    logic [15:0]   w_room;
    logic [7:0]    w_seg;
    logic [16:0]   w_next_col;
    logic          w_wrap;
    logic [7:0]    w_left_n;
    logic [15:0]   w_dest_row;

    assign w_free     = !r_out_valid || o_out_ch.ready;
    assign w_load     = !r_busy && !i_q_stat.empty;
    assign w_fire     = r_busy && w_free;
    assign o_pop      = w_load;

    assign w_room     = r_w - r_col;
    assign w_seg      = ({8'd0, r_left} < w_room) ? r_left : w_room[7:0];
    assign w_next_col = {1'b0, r_col} + {9'd0, w_seg};
    assign w_wrap     = (w_next_col >= {1'b0, r_w});
    assign w_left_n   = r_left - w_seg;
    assign w_dest_row = r_flip ? (r_h - 16'd1 - r_row) : r_row;

    always_comb begin
        n_res      = '0;
        n_res.kind = r_cur.kind;
        n_res.last = 1'b1;
        unique case (r_cur.kind)
            tga_pkg::KIND_PIXEL: begin
                n_res.dest_row   = w_dest_row;
                n_res.dest_col   = r_col;
                n_res.seg_len    = w_seg;
                n_res.red        = r_cur.red;
                n_res.green      = r_cur.green;
                n_res.blue       = r_cur.blue;
                n_res.alpha      = r_cur.alpha;
                n_res.image_done = w_wrap && (r_row == 16'd0);
                n_res.last       = (w_left_n == 8'd0);
            end
            tga_pkg::KIND_HDR_OK: begin
                n_res.img_width  = r_cur.width;
                n_res.img_height = r_cur.height;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cur       <= '0;
            r_left      <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_w         <= '0;
            r_h         <= '0;
            r_flip      <= 1'b0;
            r_out_valid <= 1'b0;
            r_res       <= '0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
                r_cur  <= i_cmd;
                r_left <= i_cmd.count;
            end
            if (w_fire) begin
                r_res <= n_res;
                if (n_res.last) begin
                    r_busy <= 1'b0;
                end
                if (r_cur.kind == tga_pkg::KIND_PIXEL) begin
                    r_left <= w_left_n;
                    if (w_wrap) begin
                        r_col <= '0;
                        r_row <= r_row - 16'd1;
                    end else begin
                        r_col <= w_next_col[15:0];
                    end
                end else if (r_cur.kind == tga_pkg::KIND_HDR_OK) begin
                    r_w    <= r_cur.width;
                    r_h    <= r_cur.height;
                    r_flip <= r_cur.flip;
                    r_col  <= '0;
                    r_row  <= r_cur.height - 16'd1;
                end
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_ch.valid      = r_out_valid;
    assign o_out_ch.kind       = r_res.kind;
    assign o_out_ch.dest_row   = r_res.dest_row;
    assign o_out_ch.dest_col   = r_res.dest_col;
    assign o_out_ch.seg_len    = r_res.seg_len;
    assign o_out_ch.red        = r_res.red;
    assign o_out_ch.green      = r_res.green;
    assign o_out_ch.blue       = r_res.blue;
    assign o_out_ch.alpha      = r_res.alpha;
    assign o_out_ch.img_width  = r_res.img_width;
    assign o_out_ch.img_height = r_res.img_height;
    assign o_out_ch.image_done = r_res.image_done;
    assign o_out_ch.last       = r_res.last;

    a_run_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_cur.kind == tga_pkg::KIND_PIXEL)) |-> (r_left != 8'd0))
        else $error("pixel run in progress with zero pixels left");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.kind == tga_pkg::KIND_PIXEL) && r_res.image_done)
            |-> r_res.last)
        else $error("final pixel segment not closing its request");

endmodule

`default_nettype wire

@@ sim/tga_rle_pixel_decoder_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tga_rle_pixel_decoder_tb
// self-checking bench: tga byte streams in, rgba row segments and verdicts out
// ============================================================================
// Drives whole tga files, broken headers and stray bytes into the decoder one
// byte per request and keeps its own decoder state to predict every result.
// Directed files cover each header verdict, zero height, the widest and
// tallest image, the id field, both depths, flipped and unflipped rows, runs
// that wrap narrow rows and overshoot the image, and restarts; they run with
// random idling on both channels. A few random files close the run. Each
// result is checked field by field against the oldest prediction.
// ============================================================================

module tga_rle_pixel_decoder_tb;

    // tga header layout and codes
    localparam bit [4:0] OFS_ID_LEN     = 5'd0;
    localparam bit [4:0] OFS_CMAP_TYPE  = 5'd1;
    localparam bit [4:0] OFS_IMG_TYPE   = 5'd2;
    localparam bit [4:0] OFS_WIDTH_LO   = 5'd12;
    localparam bit [4:0] OFS_WIDTH_HI   = 5'd13;
    localparam bit [4:0] OFS_HEIGHT_LO  = 5'd14;
    localparam bit [4:0] OFS_HEIGHT_HI  = 5'd15;
    localparam bit [4:0] OFS_DEPTH      = 5'd16;
    localparam bit [4:0] OFS_ATTR       = 5'd17;
    localparam int       ATTR_FLIP_BIT  = 5;

    localparam bit [7:0] TYPE_CMAP      = 8'd1;
    localparam bit [7:0] TYPE_RAW       = 8'd2;
    localparam bit [7:0] TYPE_RLE       = 8'd10;
    localparam bit [7:0] DEPTH_16       = 8'd16;
    localparam bit [7:0] DEPTH_24       = 8'd24;
    localparam bit [7:0] DEPTH_32       = 8'd32;
    localparam int       RUN_FLAG_BIT   = 7;
    localparam bit [15:0] MIN_WIDTH     = 16'd3;
    localparam int       MAX_SEGMENTS   = 64;

    // run length and quiet point, counted over every byte sent; end hold and stall limit in cycles
    localparam int TOTAL_ITEMS     = 260;
    localparam int QUIET_FROM      = 250;
    localparam int END_HOLD_CYCLES = 100;
    localparam int STALL_LIMIT     = 3000;

    typedef enum bit [2:0] {
        DEC_IDLE,
        DEC_HEADER,
        DEC_IDSKIP,
        DEC_PIXEL
    } t_dec_phase;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] dest_row;
        logic [15:0] dest_col;
        logic [7:0]  seg_len;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] img_width;
        logic [15:0] img_height;
        logic        image_done;
        logic        last;
    } t_result;

    // ------------------------------------------------------------------------
    // scoreboard: decoder state mirror plus the queue of awaited results
    // ------------------------------------------------------------------------
    class tga_decode_scoreboard;
        t_dec_phase phase;
        bit [4:0]  hdr_idx;
        bit [7:0]  id_left;
        bit [3:0]  img_type;
        bit [2:0]  bpp;
        bit        flip;
        bit [15:0] width;
        bit [15:0] height;
        bit [7:0]  pkt_left;
        bit        pkt_run;
        bit [1:0]  pix_idx;
        bit [23:0] pix;
        bit [15:0] src_row;
        bit [15:0] col;
        bit        cmap;

        t_result awaited[$];
        t_result step_out[$];
        int errors;
        int checked;
        int files_started;
        int kinds_seen[4];

        function new();
            clear_state();
        endfunction

        function void clear_state();
            phase    = DEC_IDLE;
            hdr_idx  = '0;
            id_left  = '0;
            img_type = '0;
            bpp      = '0;
            flip     = 1'b0;
            width    = '0;
            height   = '0;
            pkt_left = '0;
            pkt_run  = 1'b0;
            pix_idx  = '0;
            pix      = '0;
            src_row  = '0;
            col      = '0;
            cmap     = 1'b0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void add_result(tga_pkg::t_kind kind, bit [15:0] row, bit [15:0] start,
                                 bit [7:0] len, bit [23:0] bgr, bit [7:0] a,
                                 bit [15:0] w, bit [15:0] h, bit done);
            t_result r;
            r.kind       = kind;
            r.dest_row   = row;
            r.dest_col   = start;
            r.seg_len    = len;
            r.red        = bgr[23:16];
            r.green      = bgr[15:8];
            r.blue       = bgr[7:0];
            r.alpha      = a;
            r.img_width  = w;
            r.img_height = h;
            r.image_done = done;
            r.last       = 1'b0;
            step_out.push_back(r);
        endfunction

        // one segment per destination row until the run or the image ends
        function void split_run(int count, bit [7:0] a);
            int        room;
            int        seg;
            bit [15:0] row;
            bit [15:0] start;
            bit        done;
            while (count > 0 && phase == DEC_PIXEL && step_out.size() < MAX_SEGMENTS) begin
                room  = int'(width) - int'(col);
                seg   = (count < room) ? count : room;
                row   = flip ? (height - 16'd1 - src_row) : src_row;
                start = col;
                done  = 1'b0;
                col   = col + 16'(seg);
                count = count - seg;
                if (col >= width) begin
                    col = '0;
                    if (src_row == '0) begin
                        done  = 1'b1;
                        phase = DEC_IDLE;
                    end else begin
                        src_row = src_row - 16'd1;
                    end
                end
                add_result(tga_pkg::KIND_PIXEL, row, start, 8'(seg), pix, a, '0, '0, done);
            end
        endfunction

        function void header_verdict(bit [7:0] b);
            flip = b[ATTR_FLIP_BIT];
            if (img_type == '0) begin
                add_result(tga_pkg::KIND_BAD_TYPE, '0, '0, '0, '0, '0, '0, '0, 1'b0);
                phase = DEC_IDLE;
            end else if (cmap || bpp == '0 || width < MIN_WIDTH) begin
                add_result(tga_pkg::KIND_BAD_FMT, '0, '0, '0, '0, '0, '0, '0, 1'b0);
                phase = DEC_IDLE;
            end else begin
                add_result(tga_pkg::KIND_HDR_OK, '0, '0, '0, '0, '0, width, height, 1'b0);
                col = '0;
                if (height == '0) begin
                    phase = DEC_IDLE;
                end else begin
                    src_row = height - 16'd1;
                    phase   = (id_left != '0) ? DEC_IDSKIP : DEC_PIXEL;
                end
            end
        endfunction

        // accepted byte: advance the mirror and queue what it should produce
        function void note_byte(bit [7:0] b, bit sof);
            bit [7:0] a;
            int       count;
            if (sof) begin
                clear_state();
                phase = DEC_HEADER;
                files_started++;
            end
            case (phase)
                DEC_HEADER: begin
                    case (hdr_idx)
                        OFS_ID_LEN:    id_left = b;
                        OFS_CMAP_TYPE: cmap = (b != 8'd0);
                        OFS_IMG_TYPE:  img_type = (b == TYPE_RAW || b == TYPE_RLE) ? b[3:0] : '0;
                        OFS_WIDTH_LO:  width[7:0] = b;
                        OFS_WIDTH_HI:  width[15:8] = b;
                        OFS_HEIGHT_LO: height[7:0] = b;
                        OFS_HEIGHT_HI: height[15:8] = b;
                        OFS_DEPTH:     bpp = (b == DEPTH_24) ? 3'd3 :
                                             ((b == DEPTH_32) ? 3'd4 : 3'd0);
                        default: ;
                    endcase
                    if (hdr_idx < OFS_ATTR) hdr_idx = hdr_idx + 5'd1;
                    else header_verdict(b);
                end
                DEC_IDSKIP: begin
                    id_left = id_left - 8'd1;
                    if (id_left == '0) phase = DEC_PIXEL;
                end
                DEC_PIXEL: begin
                    if (img_type == 4'(TYPE_RLE) && pkt_left == '0) begin
                        // packet header: count in the low bits, run flag on top
                        pkt_left = {1'b0, b[6:0]} + 8'd1;
                        pkt_run  = b[RUN_FLAG_BIT];
                        pix_idx  = '0;
                        pix      = '0;
                    end else begin
                        if (pix_idx < 2'd3) pix = pix | (24'(b) << (8 * pix_idx));
                        if (int'(pix_idx) + 1 >= int'(bpp)) begin
                            a     = (bpp == 3'd4) ? b : tga_pkg::ALPHA_OPAQUE;
                            count = 1;
                            if (img_type == 4'(TYPE_RLE)) begin
                                if (pkt_run) begin
                                    count    = pkt_left;
                                    pkt_left = '0;
                                end else begin
                                    pkt_left = pkt_left - 8'd1;
                                end
                            end
                            pix_idx = '0;
                            split_run(count, a);
                            pix = '0;
                        end else begin
                            pix_idx = pix_idx + 2'd1;
                        end
                    end
                end
                default: ;
            endcase
            if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
            foreach (step_out[i]) awaited.push_back(step_out[i]);
            step_out.delete();
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                $error("unexpected result: kind %0d row %0d col %0d len %0d",
                       got.kind, got.dest_row, got.dest_col, got.seg_len);
                errors++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            kinds_seen[want.kind]++;
            compare("kind",       want.kind,       got.kind);
            compare("dest_row",   want.dest_row,   got.dest_row);
            compare("dest_col",   want.dest_col,   got.dest_col);
            compare("seg_len",    want.seg_len,    got.seg_len);
            compare("red",        want.red,        got.red);
            compare("green",      want.green,      got.green);
            compare("blue",       want.blue,       got.blue);
            compare("alpha",      want.alpha,      got.alpha);
            compare("img_width",  want.img_width,  got.img_width);
            compare("img_height", want.img_height, got.img_height);
            compare("image_done", want.image_done, got.image_done);
            compare("last",       want.last,       got.last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    tga_in_if  in_ch ();
    tga_out_if out_ch ();

    tga_rle_pixel_decoder dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    tga_decode_scoreboard sb;
    t_result              seen_result;
    bit [7:0]             file_bytes[$];
    int                   items_sent;
    bit                   idle_on;
    int                   stall_left;
    int                   quiet_cycles;

    // ------------------------------------------------------------------------
    // sink side: ready drops in short bursts while idling is on
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (stall_left != 0) begin
            stall_left--;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 3);
        end
        out_ch.ready = (stall_left == 0);
    end

    // result monitor: every accepted result goes to the scoreboard
    always @(posedge clk) begin
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            seen_result.kind       = out_ch.kind;
            seen_result.dest_row   = out_ch.dest_row;
            seen_result.dest_col   = out_ch.dest_col;
            seen_result.seg_len    = out_ch.seg_len;
            seen_result.red        = out_ch.red;
            seen_result.green      = out_ch.green;
            seen_result.blue       = out_ch.blue;
            seen_result.alpha      = out_ch.alpha;
            seen_result.img_width  = out_ch.img_width;
            seen_result.img_height = out_ch.img_height;
            seen_result.image_done = out_ch.image_done;
            seen_result.last       = out_ch.last;
            sb.check_result(seen_result);
        end
    end

    // watchdog: too long without any request or result moving
    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // source side tasks, called at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_byte(input bit [7:0] b, input bit sof);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid = 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        in_ch.valid         = 1'b1;
        in_ch.data_byte     = b;
        in_ch.start_of_file = sof;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        sb.note_byte(b, sof);
        items_sent++;
        @(negedge clk);
    endtask

    // first byte carries the file start
    task automatic send_file();
        foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0);
        file_bytes.delete();
    endtask

    // hold off the sender until every awaited result is in
    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    task automatic add_random_bytes(input int n);
        repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // 18 header bytes, colormap spec and origins random
    task automatic add_header(input bit [7:0] id_len, input bit [7:0] cmap_type,
                              input bit [7:0] img_type, input bit [15:0] w,
                              input bit [15:0] h, input bit [7:0] depth, input bit [7:0] attr);
        file_bytes.push_back(id_len);
        file_bytes.push_back(cmap_type);
        file_bytes.push_back(img_type);
        add_random_bytes(9);
        file_bytes.push_back(w[7:0]);
        file_bytes.push_back(w[15:8]);
        file_bytes.push_back(h[7:0]);
        file_bytes.push_back(h[15:8]);
        file_bytes.push_back(depth);
        file_bytes.push_back(attr);
    endtask

    // pixel data for npix pixels; rle runs may overshoot the image
    task automatic add_pixels(input bit [7:0] img_type, input int bpp, input int npix,
                              input bit long_runs);
        int left;
        int cnt;
        bit is_run;
        left = npix;
        while (left > 0) begin
            if (img_type == TYPE_RAW) begin
                add_random_bytes(bpp);
                left--;
            end else begin
                is_run = $urandom_range(0, 1);
                cnt    = long_runs ? $urandom_range(1, 128) : $urandom_range(1, 4);
                if (!is_run && cnt > left) cnt = left;
                file_bytes.push_back({is_run, 7'(cnt - 1)});
                add_random_bytes(is_run ? bpp : cnt * bpp);
                left -= cnt;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        bit [7:0]  f_type;
        bit [7:0]  f_depth;
        bit [7:0]  f_cmap;
        bit [7:0]  f_id;
        bit [15:0] f_w;
        bit [15:0] f_h;
        int        pick;
        int        cut;

        sb                  = new();
        rst_n               = 1'b0;
        idle_on             = 1'b0;
        stall_left          = 0;
        quiet_cycles        = 0;
        items_sent          = 0;
        in_ch.valid         = 1'b0;
        in_ch.data_byte     = 8'd0;
        in_ch.start_of_file = 1'b0;
        out_ch.ready        = 1'b1;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed files ---
        idle_on = 1'b1;

        // bytes before any file start are ignored
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h0a, 1'b0);

        // bad type is reported even with a colormap and a bad depth
        add_header(8'd0, 8'd1, TYPE_CMAP, 16'd4, 16'd2, DEPTH_16, 8'h00);
        send_file();
        // colormap present on a valid type
        add_header(8'd0, 8'd1, TYPE_RAW, 16'd4, 16'd2, DEPTH_24, 8'h00);
        send_file();
        // unsupported depth
        add_header(8'd0, 8'd0, TYPE_RLE, 16'd4, 16'd2, DEPTH_16, 8'h00);
        send_file();
        // width under the minimum
        add_header(8'd0, 8'd0, TYPE_RAW, 16'd2, 16'd2, DEPTH_32, 8'h00);
        send_file();
        // zero height: accepted, then trailing bytes are ignored
        add_header(8'd0, 8'd0, TYPE_RAW, 16'd3, 16'd0, DEPTH_24, 8'h20);
        add_random_bytes(3);
        send_file();

        // widest and tallest image, flipped, 32-bit, id field, cut off early
        add_header(8'd2, 8'd0, TYPE_RLE, 16'hffff, 16'hffff, DEPTH_32, 8'hff);
        add_random_bytes(2);
        file_bytes.push_back(8'hff);
        file_bytes.push_back(8'hff);
        file_bytes.push_back(8'hff);
        file_bytes.push_back(8'hff);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hff);
        send_file();

        // long runs wrapping narrow flipped rows; last run overshoots the image
        add_header(8'd0, 8'd0, TYPE_RLE, 16'd3, 16'd50, DEPTH_24, 8'h20);
        file_bytes.push_back(8'h01);
        add_random_bytes(6);
        file_bytes.push_back(8'hff);
        add_random_bytes(3);
        file_bytes.push_back(8'hff);
        add_random_bytes(3);
        add_random_bytes(2);
        send_file();

        // uncompressed, unflipped, one id byte, extra bytes after the image
        add_header(8'd1, 8'd0, TYPE_RAW, 16'd4, 16'd2, DEPTH_24, 8'h00);
        add_random_bytes(1 + 24 + 2);
        send_file();

        // file start in the middle of a header restarts parsing
        add_header(8'd0, 8'd0, TYPE_RAW, 16'd3, 16'd1, DEPTH_32, 8'h20);
        file_bytes = file_bytes[0:4];
        send_file();
        add_header(8'd0, 8'd0, TYPE_RAW, 16'd3, 16'd1, DEPTH_32, 8'h20);
        add_random_bytes(12);
        send_file();

        wait_drained();

        // --- random files ---
        while (items_sent < TOTAL_ITEMS) begin
            // idling comes and goes per file, and stops near the end
            idle_on = (items_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            pick    = $urandom_range(0, 9);
            if (pick < 6) begin
                // well-formed small image with random content
                f_type  = $urandom_range(0, 1) ? TYPE_RLE : TYPE_RAW;
                f_depth = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
                f_w     = 16'($urandom_range(3, 5));
                f_h     = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
                f_id    = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 3)) : 8'd0;
                add_header(f_id, 8'd0, f_type, f_w, f_h, f_depth,
                           8'($urandom_range(0, 255)));
                add_random_bytes(f_id);
                add_pixels(f_type, (f_depth == DEPTH_32) ? 4 : 3, int'(f_w) * int'(f_h),
                           $urandom_range(0, 3) == 0);
                if ($urandom_range(0, 7) == 0) begin
                    // cut short, the next file start takes over
                    cut        = $urandom_range(1, file_bytes.size() - 1);
                    file_bytes = file_bytes[0:cut - 1];
                end else begin
                    add_random_bytes($urandom_range(0, 2));
                end
                send_file();
            end else if (pick < 9) begin
                // header with fields anywhere in range, mostly rejected
                pick    = $urandom_range(0, 2);
                f_type  = (pick == 0) ? 8'($urandom_range(0, 255)) :
                          ((pick == 1) ? TYPE_RAW : TYPE_RLE);
                pick    = $urandom_range(0, 2);
                f_depth = (pick == 0) ? 8'($urandom_range(0, 255)) :
                          ((pick == 1) ? DEPTH_24 : DEPTH_32);
                f_cmap  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
                f_w     = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535)) :
                          16'($urandom_range(0, 4));
                f_h     = 16'($urandom_range(0, 65535));
                add_header(8'($urandom_range(0, 255)), f_cmap, f_type, f_w, f_h, f_depth,
                           8'($urandom_range(0, 255)));
                send_file();
            end else begin
                // stray bytes without a file start
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            if ($urandom_range(0, 5) == 0) wait_drained();
        end

        // drain, then give the block time to show any stray result
        idle_on = 1'b0;
        wait_drained();
        repeat (END_HOLD_CYCLES) @(negedge clk);

        $display("covered %0d file starts, %0d results checked", sb.files_started, sb.checked);
        $display("by kind: %0d segments, %0d headers accepted, %0d bad type, %0d bad format",
                 sb.kinds_seen[tga_pkg::KIND_PIXEL], sb.kinds_seen[tga_pkg::KIND_HDR_OK],
                 sb.kinds_seen[tga_pkg::KIND_BAD_TYPE], sb.kinds_seen[tga_pkg::KIND_BAD_FMT]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
